// ===== hw/rtl/nlg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nlg_pkg
// Shared types, constants and control records of the lattice gas update block.
// ----------------------------------------------------------------------------
package nlg_pkg;

    localparam int MAX_SIDE    = 64;
    localparam int COORD_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W      = COORD_W + 1;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
    localparam int COUNT_WIDTH = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int RND_W      = 24;
    localparam int BETA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 3'd6;

    localparam logic [1:0] SPIN_PX = 2'd0;
    localparam logic [1:0] SPIN_NX = 2'd1;
    localparam logic [1:0] SPIN_PY = 2'd2;
    localparam logic [1:0] SPIN_NY = 2'd3;

    // exponent handling
    localparam int LN2_Q16      = 45426;
    localparam int U_W          = 22;
    localparam int Q_W          = 36;
    localparam int DIV_DEN_W    = 16;
    localparam int DIV_STEPS    = Q_W;
    localparam int TAYLOR_ORDER = 10;
    localparam logic [Q_W-1:0]   EXP_SAT_Q  = Q_W'(9 * LN2_Q16);
    localparam logic [Q_W-1:0]   EXP_ZERO_Q = Q_W'(47 * LN2_Q16);
    localparam logic [U_W-1:0]   EXP_BIAS   = U_W'(47 * LN2_Q16);
    localparam logic [RND_W-1:0] W_MAX      = 24'hFFFFFF;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_HOP  = 2'd1,
        OP_FLIP = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         operation;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [1:0]         spin_code;
        logic [RND_W-1:0]   rand_val;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] new_x;
        logic [COORD_W-1:0] new_y;
        logic [1:0]         new_spin;
    } t_out_item;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] dens;
        logic [COUNT_WIDTH-1:0] horiz;
        logic [COUNT_WIDTH-1:0] vert;
    } t_counts;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_MOD1,
        S_RD2,
        S_MOD2,
        S_ADIV,
        S_AWAIT,
        S_RANGE,
        S_KRED,
        S_TINIT,
        S_TMUL,
        S_TDIV,
        S_TWAIT,
        S_FIN,
        S_DECIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic mem_rd;
        logic mod1;
        logic mod2;
        logic div_start_a;
        logic take_q_a;
        logic range_start;
        logic kred_step;
        logic taylor_init;
        logic tmul;
        logic div_start_t;
        logic take_q_t;
        logic fin;
        logic decide;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        t_op  op;
        logic rho_zero;
        logic div_done;
        logic kred_last;
        logic taylor_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/nematic_lattice_gas_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nematic_lattice_gas_update
// Monte Carlo add, hop and flip of one particle on a periodic lattice.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid/o_in_stall   i_in_data  (t_in_item)
//   out      output     o_out_valid/i_out_stall o_out_data (t_out_item)
//   cfg      input      i_cfg_we                i_cfg_idx, i_cfg_data
//
// add and hop run as read-modify-write of the count memory.
// flip divides by the site density when it is nonzero, then does ln 2 reduction
// and ten Taylor terms each with a divide, all on the one shared divider.
// after reset a clearing pass over all 4096 sites zeroes the counts; no transfer
// in is taken meanwhile. a stalled result waits in the output register.
// ----------------------------------------------------------------------------
module nematic_lattice_gas_update (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [nlg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [nlg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  nlg_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output nlg_pkg::t_out_item            o_out_data
);

    nlg_pkg::t_cmd  cmd;
    nlg_pkg::t_stat stat;

    nlg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nlg_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/nlg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nlg_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module nlg_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [nlg_pkg::Q_W-1:0]       i_num,
    input  wire [nlg_pkg::DIV_DEN_W-1:0] i_den,
    output logic                         o_done,
    output logic [nlg_pkg::Q_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(nlg_pkg::DIV_STEPS);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [nlg_pkg::Q_W-1:0]       r_quo;
    logic [nlg_pkg::DIV_DEN_W-1:0] r_rem;
    logic [nlg_pkg::DIV_DEN_W-1:0] r_den;
    logic [nlg_pkg::DIV_DEN_W:0]   rem_sh;
    logic [nlg_pkg::DIV_DEN_W:0]   rem_sub;
    logic                          fits;

    assign rem_sh  = {r_rem, r_quo[nlg_pkg::Q_W-1]};
    assign fits    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(nlg_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[nlg_pkg::Q_W-2:0], fits};
            r_rem <= fits ? rem_sub[nlg_pkg::DIV_DEN_W-1:0] : rem_sh[nlg_pkg::DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// ===== hw/rtl/nlg_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nlg_dpath
// Site count memory, configuration registers, hop and flip arithmetic.
// ----------------------------------------------------------------------------
module nlg_dpath (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [nlg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [nlg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  nlg_pkg::t_in_item             i_in_data,
    input  wire                           i_out_stall,
    output logic                          o_out_valid,
    output nlg_pkg::t_out_item            o_out_data,
    input  nlg_pkg::t_cmd                 i_cmd,
    output nlg_pkg::t_stat                o_stat
);

    localparam int CW = nlg_pkg::COORD_W;
    localparam int SW = nlg_pkg::SIDE_W;
    localparam int AW = nlg_pkg::ADDR_W;
    localparam int NW = 4;

    // configuration
    logic [SW-1:0]                r_width, r_height;
    logic [nlg_pkg::RND_W-1:0]    r_thr1, r_thr2, r_thr3, r_rot;
    logic [nlg_pkg::BETA_W-1:0]   r_beta;

    // item
    nlg_pkg::t_op                 r_op;
    logic [CW-1:0]                r_x, r_y;
    logic [1:0]                   r_spin;
    logic [nlg_pkg::RND_W-1:0]    r_rnd;
    logic [AW-1:0]                r_addr;
    logic [AW-1:0]                r_clr;

    // memory
    nlg_pkg::t_counts             r_mem [nlg_pkg::DEPTH];
    nlg_pkg::t_counts             r_rdata;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    nlg_pkg::t_counts             mem_wdata;

    // flip arithmetic
    nlg_pkg::t_counts             r_cnt;
    logic                         r_diffneg;
    logic [31:0]                  r_prod;
    logic [nlg_pkg::Q_W-1:0]      r_q;
    logic                         r_wsat, r_wzero;
    logic [nlg_pkg::U_W-1:0]      r_u;
    logic [2:0]                   r_kcnt;
    logic [5:0]                   r_kq;
    logic [31:0]                  r_term, r_sum, r_tprod;
    logic [NW-1:0]                r_n;
    logic [nlg_pkg::RND_W-1:0]    r_w;

    logic                         r_out_valid;
    nlg_pkg::t_out_item           r_out;

    logic                         div_start;
    logic [nlg_pkg::Q_W-1:0]      div_num;
    logic [nlg_pkg::DIV_DEN_W-1:0] div_den;
    logic                         div_done;
    logic [nlg_pkg::Q_W-1:0]      div_q;

    logic [SW-1:0]                side_w, side_h;
    logic                         horiz;

    function automatic logic [SW-1:0] side_of(input logic [SW-1:0] v);
        if (v == '0) begin
            side_of = SW'(1);
        end else if (v > SW'(nlg_pkg::MAX_SIDE)) begin
            side_of = SW'(nlg_pkg::MAX_SIDE);
        end else begin
            side_of = v;
        end
    endfunction

    function automatic logic [CW-1:0] clamp(input logic [CW-1:0] c, input logic [SW-1:0] s);
        logic [SW-1:0] last;
        last = s - 1'b1;
        clamp = ({1'b0, c} >= s) ? last[CW-1:0] : c;
    endfunction

    function automatic logic [CW-1:0] step(input logic [CW-1:0] c, input logic up,
                                           input logic [SW-1:0] s);
        logic [SW-1:0] inc;
        logic [SW-1:0] last;
        inc  = {1'b0, c} + 1'b1;
        last = s - 1'b1;
        if (up) begin
            step = (inc >= s) ? '0 : inc[CW-1:0];
        end else begin
            step = (c == '0) ? last[CW-1:0] : c - 1'b1;
        end
    endfunction

    function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                                input logic [SW-1:0] s);
        logic [AW:0] prod;
        prod = {{(AW+1-CW){1'b0}}, y} * {{(AW+1-SW){1'b0}}, s};
        site_addr = prod[AW-1:0] + {{(AW-CW){1'b0}}, x};
    endfunction

    function automatic nlg_pkg::t_counts bump(input nlg_pkg::t_counts c, input logic hz,
                                             input logic up);
        nlg_pkg::t_counts r;
        logic [nlg_pkg::COUNT_WIDTH-1:0] d;
        d = up ? nlg_pkg::COUNT_WIDTH'(1) : '1;
        r = c;
        r.dens = c.dens + d;
        if (hz) begin
            r.horiz = c.horiz + d;
        end else begin
            r.vert = c.vert + d;
        end
        bump = r;
    endfunction

    assign side_w = side_of(r_width);
    assign side_h = side_of(r_height);
    assign horiz  = ~r_spin[1];

    // ---------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SW'(64);
            r_height <= SW'(64);
            r_thr1   <= 24'd65536;
            r_thr2   <= 24'd131072;
            r_thr3   <= 24'd196608;
            r_rot    <= 24'd262144;
            r_beta   <= 16'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nlg_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[SW-1:0];
                nlg_pkg::CFG_HEIGHT: r_height <= i_cfg_data[SW-1:0];
                nlg_pkg::CFG_THR1:   r_thr1   <= i_cfg_data;
                nlg_pkg::CFG_THR2:   r_thr2   <= i_cfg_data;
                nlg_pkg::CFG_THR3:   r_thr3   <= i_cfg_data;
                nlg_pkg::CFG_ROT:    r_rot    <= i_cfg_data;
                nlg_pkg::CFG_BETA:   r_beta   <= i_cfg_data[nlg_pkg::BETA_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // ---------------- hop and flip decisions
    logic [CW-1:0]   hop_x, hop_y;
    logic            pos_dir;
    logic [16:0]     diff;
    logic [15:0]     mag;

    always_comb begin
        pos_dir = ~r_spin[0];
        hop_x   = r_x;
        hop_y   = r_y;
        if (horiz) begin
            if (r_rnd < r_thr1) begin
                hop_y = step(r_y, 1'b1, side_h);
            end else if (r_rnd < r_thr2) begin
                hop_y = step(r_y, 1'b0, side_h);
            end else if (r_rnd < r_thr3) begin
                hop_x = step(r_x, pos_dir, side_w);
            end else begin
                hop_x = step(r_x, ~pos_dir, side_w);
            end
        end else begin
            if (r_rnd < r_thr1) begin
                hop_x = step(r_x, 1'b1, side_w);
            end else if (r_rnd < r_thr2) begin
                hop_x = step(r_x, 1'b0, side_w);
            end else if (r_rnd < r_thr3) begin
                hop_y = step(r_y, pos_dir, side_h);
            end else begin
                hop_y = step(r_y, ~pos_dir, side_h);
            end
        end
        diff = {1'b0, r_rdata.horiz} - {1'b0, r_rdata.vert};
        mag  = diff[16] ? 16'(-diff) : diff[15:0];
    end

    // final weight and spin decision
    logic [5:0]                 sh;
    logic [32:0]                rnd_sum;
    logic [32:0]                shifted;
    logic [nlg_pkg::RND_W-1:0]  w_calc;
    logic signed [25:0]         rate, wt1, wt2;
    logic                       lt1, lt2, turn;
    logic [1:0]                 new_spin;
    logic [nlg_pkg::U_W-1:0]    ln2_sh;
    logic                       eneg;

    always_comb begin
        sh      = 6'd62 - r_kq;
        rnd_sum = {1'b0, r_sum} + (33'd1 << (sh - 1'b1));
        shifted = rnd_sum >> sh;
        if (r_wsat) begin
            w_calc = nlg_pkg::W_MAX;
        end else if (r_wzero || sh > 6'd32) begin
            w_calc = '0;
        end else if (shifted > {9'd0, nlg_pkg::W_MAX}) begin
            w_calc = nlg_pkg::W_MAX;
        end else begin
            w_calc = shifted[nlg_pkg::RND_W-1:0];
        end

        rate = $signed({2'b00, r_rnd}) - $signed({2'b00, r_rot});
        wt1  = $signed({2'b00, r_w});
        wt2  = $signed({1'b0, r_w, 1'b0});
        lt1  = rate < wt1;
        lt2  = rate < wt2;
        turn = lt1 || lt2;
        if (horiz) begin
            new_spin = lt1 ? nlg_pkg::SPIN_PY : (lt2 ? nlg_pkg::SPIN_NY : r_spin);
        end else begin
            new_spin = lt1 ? nlg_pkg::SPIN_PX : (lt2 ? nlg_pkg::SPIN_NX : r_spin);
        end

        ln2_sh = nlg_pkg::U_W'(nlg_pkg::LN2_Q16) << r_kcnt;
        eneg   = horiz ^ r_diffneg;
    end

    // ---------------- item and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= nlg_pkg::t_op'(i_in_data.operation);
            r_x    <= clamp(i_in_data.pos_x, side_w);
            r_y    <= clamp(i_in_data.pos_y, side_h);
            r_spin <= i_in_data.spin_code;
            r_rnd  <= i_in_data.rand_val;
            r_addr <= site_addr(clamp(i_in_data.pos_x, side_w),
                                clamp(i_in_data.pos_y, side_h), side_w);
        end
        if (i_cmd.mod1) begin
            r_cnt     <= r_rdata;
            r_diffneg <= diff[16];
            r_prod    <= {16'd0, r_beta} * {16'd0, mag};
            r_q       <= '0;
            if (r_op == nlg_pkg::OP_HOP) begin
                r_x    <= hop_x;
                r_y    <= hop_y;
                r_addr <= site_addr(hop_x, hop_y, side_w);
            end
        end
        if (i_cmd.take_q_a) begin
            r_q <= div_q;
        end
        if (i_cmd.range_start) begin
            r_wsat  <= !eneg && (r_q >= nlg_pkg::EXP_SAT_Q);
            r_wzero <= eneg && (r_q > nlg_pkg::EXP_ZERO_Q);
            r_u     <= eneg ? nlg_pkg::EXP_BIAS - r_q[nlg_pkg::U_W-1:0]
                            : nlg_pkg::EXP_BIAS + r_q[nlg_pkg::U_W-1:0];
            r_kcnt  <= 3'd5;
            r_kq    <= '0;
        end
        // range reduction by ln 2, one quotient bit a cycle
        if (i_cmd.kred_step) begin
            if (r_u >= ln2_sh) begin
                r_u          <= r_u - ln2_sh;
                r_kq[r_kcnt] <= 1'b1;
            end
            r_kcnt <= r_kcnt - 1'b1;
        end
        if (i_cmd.taylor_init) begin
            r_term <= 32'd1 << 30;
            r_sum  <= 32'd1 << 30;
            r_n    <= NW'(1);
        end
        if (i_cmd.tmul) begin
            r_tprod <= 32'(({16'd0, r_term} * {32'd0, r_u[15:0]}) >> 16);
        end
        if (i_cmd.take_q_t) begin
            r_term <= div_q[31:0];
            r_sum  <= r_sum + div_q[31:0];
            r_n    <= r_n + 1'b1;
        end
        if (i_cmd.fin) begin
            r_w <= w_calc;
        end
        if (i_cmd.decide) begin
            r_spin <= new_spin;
        end
    end

    // ---------------- site count memory
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rdata;
        if (i_cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (i_cmd.mod1) begin
            mem_we    = (r_op == nlg_pkg::OP_ADD) || (r_op == nlg_pkg::OP_HOP);
            mem_wdata = bump(r_rdata, horiz, r_op == nlg_pkg::OP_ADD);
        end else if (i_cmd.mod2) begin
            mem_we    = 1'b1;
            mem_wdata = bump(r_rdata, horiz, 1'b1);
        end else if (i_cmd.decide) begin
            mem_we    = turn;
            mem_wdata = r_cnt;
            if (horiz) begin
                mem_wdata.horiz = r_cnt.horiz - 1'b1;
                mem_wdata.vert  = r_cnt.vert + 1'b1;
            end else begin
                mem_wdata.horiz = r_cnt.horiz + 1'b1;
                mem_wdata.vert  = r_cnt.vert - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // ---------------- shared divider
    assign div_start = i_cmd.div_start_a | i_cmd.div_start_t;
    assign div_num   = i_cmd.div_start_a ? {r_prod, 4'd0} : {4'd0, r_tprod};
    assign div_den   = i_cmd.div_start_a ? r_cnt.dens
                                         : {{(nlg_pkg::DIV_DEN_W-NW){1'b0}}, r_n};

    nlg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.new_x    <= r_x;
            r_out.new_y    <= r_y;
            r_out.new_spin <= r_spin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_stat.clr_last    = (r_clr == AW'(nlg_pkg::DEPTH - 1));
        o_stat.op          = r_op;
        o_stat.rho_zero    = (r_rdata.dens == '0);
        o_stat.div_done    = div_done;
        o_stat.kred_last   = (r_kcnt == 3'd0);
        o_stat.taylor_last = (r_n == NW'(nlg_pkg::TAYLOR_ORDER));
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/nlg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nlg_ctrl
// Sequencer: clearing pass, read-modify-write of counts, flip weight steps.
// ----------------------------------------------------------------------------
module nlg_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  nlg_pkg::t_stat i_stat,
    output nlg_pkg::t_cmd  o_cmd
);

    nlg_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nlg_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nlg_pkg::S_CLEAR:  if (i_stat.clr_last) n_state = nlg_pkg::S_IDLE;
            nlg_pkg::S_IDLE:   if (i_in_valid) n_state = nlg_pkg::S_RD1;
            nlg_pkg::S_RD1:    n_state = nlg_pkg::S_MOD1;
            nlg_pkg::S_MOD1: begin
                case (i_stat.op)
                    nlg_pkg::OP_HOP:  n_state = nlg_pkg::S_RD2;
                    nlg_pkg::OP_FLIP: n_state = i_stat.rho_zero ? nlg_pkg::S_RANGE
                                                                : nlg_pkg::S_ADIV;
                    default:          n_state = nlg_pkg::S_DONE;
                endcase
            end
            nlg_pkg::S_RD2:    n_state = nlg_pkg::S_MOD2;
            nlg_pkg::S_MOD2:   n_state = nlg_pkg::S_DONE;
            nlg_pkg::S_ADIV:   n_state = nlg_pkg::S_AWAIT;
            nlg_pkg::S_AWAIT:  if (i_stat.div_done) n_state = nlg_pkg::S_RANGE;
            nlg_pkg::S_RANGE:  n_state = nlg_pkg::S_KRED;
            nlg_pkg::S_KRED:   if (i_stat.kred_last) n_state = nlg_pkg::S_TINIT;
            nlg_pkg::S_TINIT:  n_state = nlg_pkg::S_TMUL;
            nlg_pkg::S_TMUL:   n_state = nlg_pkg::S_TDIV;
            nlg_pkg::S_TDIV:   n_state = nlg_pkg::S_TWAIT;
            nlg_pkg::S_TWAIT: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.taylor_last ? nlg_pkg::S_FIN : nlg_pkg::S_TMUL;
                end
            end
            nlg_pkg::S_FIN:    n_state = nlg_pkg::S_DECIDE;
            nlg_pkg::S_DECIDE: n_state = nlg_pkg::S_DONE;
            nlg_pkg::S_DONE:   if (i_stat.out_free) n_state = nlg_pkg::S_IDLE;
            default:           n_state = nlg_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_in_stall        = (r_state != nlg_pkg::S_IDLE);
        case (r_state)
            nlg_pkg::S_CLEAR:  o_cmd.clr_step    = 1'b1;
            nlg_pkg::S_IDLE:   o_cmd.load_item   = i_in_valid;
            nlg_pkg::S_RD1:    o_cmd.mem_rd      = 1'b1;
            nlg_pkg::S_MOD1:   o_cmd.mod1        = 1'b1;
            nlg_pkg::S_RD2:    o_cmd.mem_rd      = 1'b1;
            nlg_pkg::S_MOD2:   o_cmd.mod2        = 1'b1;
            nlg_pkg::S_ADIV:   o_cmd.div_start_a = 1'b1;
            nlg_pkg::S_AWAIT:  o_cmd.take_q_a    = i_stat.div_done;
            nlg_pkg::S_RANGE:  o_cmd.range_start = 1'b1;
            nlg_pkg::S_KRED:   o_cmd.kred_step   = 1'b1;
            nlg_pkg::S_TINIT:  o_cmd.taylor_init = 1'b1;
            nlg_pkg::S_TMUL:   o_cmd.tmul        = 1'b1;
            nlg_pkg::S_TDIV:   o_cmd.div_start_t = 1'b1;
            nlg_pkg::S_TWAIT:  o_cmd.take_q_t    = i_stat.div_done;
            nlg_pkg::S_FIN:    o_cmd.fin         = 1'b1;
            nlg_pkg::S_DECIDE: o_cmd.decide      = 1'b1;
            nlg_pkg::S_DONE:   o_cmd.out_load    = i_stat.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire
